>>> design/assert_macros.svh
// Assertion macros shared by the date key exchange sort RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DKES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen outside reset.
`define DKES_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> design/dkes_pkg.sv
// Package: record type, key function, sequencer states and defaults.
package dkes_pkg;

    localparam int DKES_MAX_ENTRIES = 64;
    localparam int DKES_KEY_W       = 23;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] tag;
        logic [1:0]  status;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_LI,
        ST_SORT_CMP,
        ST_SORT_WI,
        ST_OUT_RD,
        ST_OUT_LD
    } dkes_state_t;

    function automatic logic [DKES_KEY_W-1:0] rec_key(input rec_t r);
        rec_key = {r.year, r.month, r.day};
    endfunction

endpackage

>>> design/dkes_if.sv
// Valid/ready channel interfaces for record items in and sorted items out.
interface dkes_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
    logic [15:0] in_tag;
    logic [1:0]  in_status;
    logic        in_last;

    modport source (output valid, in_day, in_month, in_year, in_tag, in_status, in_last,
                    input ready);
    modport sink   (input valid, in_day, in_month, in_year, in_tag, in_status, in_last,
                    output ready);
endinterface

interface dkes_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [15:0] out_tag;
    logic [1:0]  out_status;
    logic        out_last;
    logic        out_overflow;

    modport source (output valid, out_day, out_month, out_year, out_tag, out_status,
                    out_last, out_overflow, input ready);
    modport sink   (input valid, out_day, out_month, out_year, out_tag, out_status,
                    out_last, out_overflow, output ready);
endinterface

>>> design/dkes_store.sv
// Record store: single write port, single registered read port.
module dkes_store
    import dkes_pkg::*;
#(
    parameter int DEPTH = DKES_MAX_ENTRIES,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rec_t          wr_data,
    input  logic [AW-1:0] rd_addr,
    output rec_t          rd_data
);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/date_key_exchange_sort.sv
// Date key exchange sort: batch record store, sorter sequencer and output register.
//
// rec_in (sink) takes one record per item; ready is high while the block loads.
// An item with in_last set closes the batch (even when dropped for lack of space).
// Records beyond MAX_ENTRIES are dropped; every result of that batch has out_overflow.
// After the batch end the block sorts in place by (year, month, day) with an exchange
// sort: entry i is held in a register and compared against entries j > i, one compare
// per cycle through the single read and write port of the record store.
// Then one result per cycle leaves on rec_out (source) while the receiver is ready,
// the final one marked out_last. Loading runs at one item per cycle; the compare
// loop over the store sets the batch end cost.
// rec_out has an output register: a stalled receiver holds the sequencer in its
// output phase, and the last result may wait while the next batch loads.
// Reset empties the store count, clears the overflow mark and drops any pending result;
// the store contents need no clearing.
module date_key_exchange_sort
    import dkes_pkg::*;
    `include "assert_macros.svh"
#(
    parameter int MAX_ENTRIES = DKES_MAX_ENTRIES
)
(
    input  logic          clk,
    input  logic          rst_n,
    dkes_in_if.sink       rec_in,
    dkes_out_if.source    rec_out
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    dkes_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    rec_t          cur_reg, cur_next;

    logic          out_valid_reg, out_valid_next;
    rec_t          out_rec_reg, out_rec_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    rec_t          wr_data;
    logic [AW-1:0] rd_addr;
    rec_t          rd_data;

    logic          accept;
    logic          full;
    rec_t          in_rec;
    logic [CW-1:0] n_new;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] last_idx;
    logic [AW-1:0] i_inc;
    logic [AW-1:0] j_inc;
    logic [AW-1:0] k_inc;
    logic          out_load;
    logic          swap;

    dkes_store #(
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rec_in.ready = (state_reg == ST_IDLE);
    assign accept       = rec_in.valid && rec_in.ready;
    assign full         = (count_reg == CW'(MAX_ENTRIES));
    assign n_new        = full ? count_reg : count_reg + 1'b1;
    assign cnt_m1       = count_reg - 1'b1;
    assign last_idx     = cnt_m1[AW-1:0];
    assign i_inc        = i_reg + 1'b1;
    assign j_inc        = j_reg + 1'b1;
    assign k_inc        = k_reg + 1'b1;
    assign out_load     = (state_reg == ST_OUT_LD) && (!out_valid_reg || rec_out.ready);
    assign swap         = rec_key(cur_reg) > rec_key(rd_data);

    assign in_rec.year   = rec_in.in_year;
    assign in_rec.month  = rec_in.in_month;
    assign in_rec.day    = rec_in.in_day;
    assign in_rec.tag    = rec_in.in_tag;
    assign in_rec.status = rec_in.in_status;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && rec_in.in_last)
                begin
                    state_next = (n_new > CW'(1)) ? ST_SORT_LI : ST_OUT_RD;
                end
            end
            ST_SORT_LI:
            begin
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                if (j_reg == last_idx)
                begin
                    state_next = ST_SORT_WI;
                end
            end
            ST_SORT_WI:
            begin
                state_next = (i_inc == last_idx) ? ST_OUT_RD : ST_SORT_LI;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (out_load && (k_reg == last_idx))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !rec_out.ready;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = cur_reg;
        rd_addr        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        wr_data    = in_rec;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (rec_in.in_last)
                    begin
                        i_next = '0;
                        j_next = AW'(1);
                        k_next = '0;
                    end
                end
            end
            ST_SORT_LI:
            begin
                cur_next = rd_data;
                rd_addr  = j_reg;
            end
            ST_SORT_CMP:
            begin
                rd_addr = j_inc;
                j_next  = j_inc;
                if (swap)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = j_reg;
                    wr_data  = cur_reg;
                    cur_next = rd_data;
                end
            end
            ST_SORT_WI:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = cur_reg;
                k_next  = '0;
                i_next  = i_inc;
                j_next  = i_inc + 1'b1;
                rd_addr = i_inc;
            end
            ST_OUT_RD:
            begin
                rd_addr = k_reg;
            end
            ST_OUT_LD:
            begin
                rd_addr = k_reg;
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_rec_next   = rd_data;
                    out_last_next  = (k_reg == last_idx);
                    out_ovf_next   = dropped_reg;
                    if (k_reg == last_idx)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        k_next  = k_inc;
                        rd_addr = k_inc;
                    end
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign rec_out.valid        = out_valid_reg;
    assign rec_out.out_day      = out_rec_reg.day;
    assign rec_out.out_month    = out_rec_reg.month;
    assign rec_out.out_year     = out_rec_reg.year;
    assign rec_out.out_tag      = out_rec_reg.tag;
    assign rec_out.out_status   = out_rec_reg.status;
    assign rec_out.out_last     = out_last_reg;
    assign rec_out.out_overflow = out_ovf_reg;

    `DKES_ASSERT(a_cnt_range, count_reg <= CW'(MAX_ENTRIES), "entry count above capacity")
    `DKES_ASSERT(a_drop_full, dropped_reg |-> full, "drop marked with store not full")
    `DKES_ASSERT(a_cmp_order, (state_reg == ST_SORT_CMP) |-> (j_reg > i_reg),
        "compare index not above held index")
    `DKES_ASSERT(a_batch_clear, (out_load && out_last_next) |=>
        (count_reg == '0 && !dropped_reg && state_reg == ST_IDLE),
        "batch not cleared after final item")
    `DKES_ASSERT_NEVER(a_no_wr_out,
        wr_en && (state_reg == ST_OUT_RD || state_reg == ST_OUT_LD),
        "store written during output phase")

endmodule
